// ===== hw/rtl/baro_pkg.sv =====
// ----------------------------------------------------------------------------
// baro_pkg
// Shared types, constants and arithmetic helpers for the barometric
// temperature and pressure compensation pipeline.
// ----------------------------------------------------------------------------
package baro_pkg;

    localparam int NUM_DIV_STEPS = 16;  // two quotient bits per stage
    localparam int ST_CAP   = 0;
    localparam int ST_X1    = 1;
    localparam int ST_DIV1  = 2;
    localparam int ST_B5    = ST_DIV1 + NUM_DIV_STEPS + 1;
    localparam int ST_B6    = ST_B5 + 1;
    localparam int ST_MUL1  = ST_B6 + 1;
    localparam int ST_MUL2  = ST_MUL1 + 1;
    localparam int ST_B3    = ST_MUL2 + 1;
    localparam int ST_B4    = ST_B3 + 1;
    localparam int ST_DIV2  = ST_B4 + 1;
    localparam int ST_P     = ST_DIV2 + NUM_DIV_STEPS + 1;
    localparam int ST_PSQ   = ST_P + 1;
    localparam int ST_PX1   = ST_PSQ + 1;
    localparam int ST_OUT   = ST_PX1 + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    localparam logic [2:0] REG_AC1_AC2 = 3'd0;
    localparam logic [2:0] REG_AC3_AC4 = 3'd1;
    localparam logic [2:0] REG_AC5_AC6 = 3'd2;
    localparam logic [2:0] REG_B1_B2   = 3'd3;
    localparam logic [2:0] REG_MC_MD   = 3'd4;
    localparam logic [2:0] REG_OSS     = 3'd5;

    localparam logic [31:0] C_4000  = 32'd4000;
    localparam logic [31:0] C_3038  = 32'd3038;
    localparam logic [31:0] C_M7357 = 32'hFFFF_E343;
    localparam logic [31:0] C_3791  = 32'd3791;
    localparam logic [31:0] C_50000 = 32'd50000;
    localparam logic [31:0] C_32768 = 32'd32768;
    localparam logic [31:0] C_MSB   = 32'h8000_0000;
    localparam logic [31:0] P_MAX   = 32'd262143;

    typedef struct packed {
        logic [18:0] up;
        logic [15:0] temp;
        logic        err;
        logic        neg;
        logic        dbl;
        logic [31:0] x1;
        logic [31:0] b5;
        logic [31:0] b6;
        logic [31:0] sq12;
        logic [31:0] x2a;
        logic [31:0] x1b;
        logic [31:0] x1a;
        logic [31:0] x2b;
        logic [31:0] b3;
        logic [31:0] x3b;
        logic [31:0] b4;
        logic [31:0] dif;
        logic [31:0] p;
        logic [31:0] psq;
        logic [31:0] x2p;
        logic [31:0] x1p;
        logic [31:0] divisor;
        logic [31:0] rem;
        logic [31:0] quo;
    } stage_t;

    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        logic signed [31:0] s;
        s = $signed(x) >>> n;
        return $unsigned(s);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] h);
        return {{16{h[15]}}, h};
    endfunction

    function automatic logic [31:0] mag(input logic [31:0] x);
        return x[31] ? (32'd0 - x) : x;
    endfunction

    // two restoring division steps: quo shifts out dividend, shifts in quotient
    function automatic stage_t div_step(input stage_t s);
        logic [32:0] t;
        stage_t      r;
        r = s;
        for (int k = 0; k < 2; k++) begin
            t = {r.rem, r.quo[31]};
            if (t >= {1'b0, r.divisor}) begin
                t = t - {1'b0, r.divisor};
                r.quo = {r.quo[30:0], 1'b1};
            end else begin
                r.quo = {r.quo[30:0], 1'b0};
            end
            r.rem = t[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/baro_temp_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Pipelined integer compensation of raw temperature and pressure readings.
// ----------------------------------------------------------------------------
// Input channel s_*: one raw temperature and raw pressure reading per transfer.
// Result channel m_*: compensated temperature (0.1 degC), pressure (Pa) and a
// divide error flag, one result per input transfer, in order.
// Calibration words and oversampling must be written through cfg_* only
// while idle; the block does not enforce this. cfg_ready is always high,
// indices above 5 are ignored. One item is taken every cycle while the
// output does not stall the pipeline. The design is a 46-stage pipeline,
// whose two dividers each resolve two quotient bits per stage over 16 stages.
// When m_ready is low with a result waiting, the whole pipeline holds and
// s_ready drops; nothing is lost or repeated.
// Reset clears all calibration registers and empties the pipeline.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_raw_temperature,
    input  logic [18:0] s_raw_pressure,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_temperature,
    output logic [17:0] m_pressure,
    output logic        m_divide_error,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import baro_pkg::*;

    logic [31:0] ac12_reg, ac34_reg, ac56_reg, b12_reg, mcmd_reg;
    logic [1:0]  oss_reg;
    stage_t      pipe_reg  [NUM_STAGES];
    stage_t      pipe_next [NUM_STAGES];
    logic        vld_reg   [NUM_STAGES];
    logic        adv;

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

    assign ac1 = sx16(ac12_reg[31:16]);
    assign ac2 = sx16(ac12_reg[15:0]);
    assign ac3 = sx16(ac34_reg[31:16]);
    assign ac4 = {16'd0, ac34_reg[15:0]};
    assign ac5 = {16'd0, ac56_reg[31:16]};
    assign ac6 = {16'd0, ac56_reg[15:0]};
    assign b1  = sx16(b12_reg[31:16]);
    assign b2  = sx16(b12_reg[15:0]);
    assign mc  = sx16(mcmd_reg[31:16]);
    assign md  = sx16(mcmd_reg[15:0]);

    assign cfg_ready = 1'b1;
    assign adv       = !vld_reg[NUM_STAGES-1] || m_ready;
    assign s_ready   = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ac12_reg <= '0;
            ac34_reg <= '0;
            ac56_reg <= '0;
            b12_reg  <= '0;
            mcmd_reg <= '0;
            oss_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_AC1_AC2: ac12_reg <= cfg_data;
                REG_AC3_AC4: ac34_reg <= cfg_data;
                REG_AC5_AC6: ac56_reg <= cfg_data;
                REG_B1_B2:   b12_reg  <= cfg_data;
                REG_MC_MD:   mcmd_reg <= cfg_data;
                REG_OSS:     oss_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        stage_t      s;
        logic [31:0] v0, v1, v2;
        logic [31:0] num;
        for (int i = 0; i < NUM_STAGES; i++) begin
            s  = (i == 0) ? pipe_reg[0] : pipe_reg[(i == 0) ? 0 : i - 1];
            v0 = '0;
            v1 = '0;
            v2 = '0;
            num = '0;
            if (i == ST_CAP) begin
                s.up = s_raw_pressure;
                s.x1 = {16'd0, s_raw_temperature} - ac6;
            end else if (i == ST_X1) begin
                v0   = s.x1 * ac5;
                s.x1 = asr(v0, 15);
            end else if (i == ST_DIV1) begin
                num       = mc << 11;
                v0        = s.x1 + md;
                s.err     = (v0 == 32'd0);
                s.neg     = num[31] ^ v0[31];
                s.divisor = mag(v0);
                s.rem     = '0;
                s.quo     = mag(num);
            end else if ((i > ST_DIV1 && i < ST_B5) || (i > ST_DIV2 && i < ST_P)) begin
                s = div_step(s);
            end else if (i == ST_B5) begin
                v0   = s.err ? 32'd0 : (s.neg ? (32'd0 - s.quo) : s.quo);
                s.b5 = s.x1 + v0;
            end else if (i == ST_B6) begin
                v0 = asr(s.b5 + 32'd8, 4);
                if (!v0[31] && v0 > 32'h0000_7FFF) begin
                    s.temp = 16'h7FFF;
                end else if (v0[31] && v0 < 32'hFFFF_8000) begin
                    s.temp = 16'h8000;
                end else begin
                    s.temp = v0[15:0];
                end
                s.b6 = s.b5 - C_4000;
            end else if (i == ST_MUL1) begin
                v0     = s.b6 * s.b6;
                v1     = ac2 * s.b6;
                v2     = ac3 * s.b6;
                s.sq12 = asr(v0, 12);
                s.x2a  = asr(v1, 11);
                s.x1b  = asr(v2, 13);
            end else if (i == ST_MUL2) begin
                v0    = b2 * s.sq12;
                v1    = b1 * s.sq12;
                s.x1a = asr(v0, 11);
                s.x2b = asr(v1, 16);
            end else if (i == ST_B3) begin
                v0    = ((ac1 << 2) + s.x1a + s.x2a) << oss_reg;
                s.b3  = asr(v0 + 32'd2, 2);
                s.x3b = asr(s.x1b + s.x2b + 32'd2, 2);
            end else if (i == ST_B4) begin
                v0    = ac4 * (s.x3b + C_32768);
                s.b4  = v0 >> 15;
                s.dif = {13'd0, s.up} - s.b3;
            end else if (i == ST_DIV2) begin
                v0        = s.dif * (C_50000 >> oss_reg);
                s.err     = s.err || (s.b4 == 32'd0);
                s.dbl     = (v0 >= C_MSB);
                s.quo     = s.dbl ? v0 : (v0 << 1);
                s.rem     = '0;
                s.divisor = s.b4;
            end else if (i == ST_P) begin
                s.p = s.dbl ? (s.quo << 1) : s.quo;
            end else if (i == ST_PSQ) begin
                v0    = asr(s.p, 8);
                s.psq = v0 * v0;
                v1    = C_M7357 * s.p;
                s.x2p = asr(v1, 16);
            end else if (i == ST_PX1) begin
                v0    = s.psq * C_3038;
                s.x1p = asr(v0, 16);
            end else begin
                v0 = s.p + asr(s.x1p + s.x2p + C_3791, 4);
                if (s.err || v0[31]) begin
                    s.p = '0;
                end else if (v0 > P_MAX) begin
                    s.p = P_MAX;
                end else begin
                    s.p = v0;
                end
            end
            pipe_next[i] = s;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < NUM_STAGES; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign m_valid        = vld_reg[NUM_STAGES-1];
    assign m_temperature  = pipe_reg[NUM_STAGES-1].temp;
    assign m_pressure     = pipe_reg[NUM_STAGES-1].p[17:0];
    assign m_divide_error = pipe_reg[NUM_STAGES-1].err;

endmodule

// ===== tb/baro_temp_pressure_compensation_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_tb
// Drives raw temperature/pressure readings under several calibration sets
// and oversampling settings, predicts compensated outputs with an integer
// model, and checks every result transfer in order. Sender and receiver
// idle at random, at rates that change over three phases; the last has none.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_tb;
    import baro_pkg::*;

    typedef struct packed {
        logic [15:0] ut;
        logic [18:0] up;
    } reading_t;

    typedef struct packed {
        logic [15:0] temp;
        logic [17:0] pres;
        logic        err;
    } comp_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_raw_temperature;
    logic [18:0] s_raw_pressure;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_temperature;
    logic [17:0] m_pressure;
    logic        m_divide_error;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    reading_t pending_q[$];
    comp_t    expected_q[$];
    logic [31:0] cal_regs[0:5];
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  failed;
    bit  send_hold;

    baro_temp_pressure_compensation u_top (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [31:0] shr_s(input logic [31:0] x, input int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] ext16(input logic [15:0] h);
        return {{16{h[15]}}, h};
    endfunction

    function automatic logic [31:0] div_trunc(input logic [31:0] num,
                                              input logic [31:0] den);
        logic [31:0] an, ad, q;
        an = num[31] ? -num : num;
        ad = den[31] ? -den : den;
        q = an / ad;
        return (num[31] != den[31]) ? -q : q;
    endfunction

    function automatic comp_t compensate(input reading_t r);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, t, den, sq;
        logic [1:0]  oss;
        bit          err;
        comp_t       c;
        ac1 = ext16(cal_regs[REG_AC1_AC2][31:16]);
        ac2 = ext16(cal_regs[REG_AC1_AC2][15:0]);
        ac3 = ext16(cal_regs[REG_AC3_AC4][31:16]);
        ac4 = {16'd0, cal_regs[REG_AC3_AC4][15:0]};
        ac5 = {16'd0, cal_regs[REG_AC5_AC6][31:16]};
        ac6 = {16'd0, cal_regs[REG_AC5_AC6][15:0]};
        b1 = ext16(cal_regs[REG_B1_B2][31:16]);
        b2 = ext16(cal_regs[REG_B1_B2][15:0]);
        mc = ext16(cal_regs[REG_MC_MD][31:16]);
        md = ext16(cal_regs[REG_MC_MD][15:0]);
        oss = cal_regs[REG_OSS][1:0];
        err = 0;
        x1 = shr_s(({16'd0, r.ut} - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) begin
            err = 1;
            x2 = 0;
        end else begin
            x2 = div_trunc(mc * 32'd2048, den);
        end
        b5 = x1 + x2;
        t = shr_s(b5 + 32'd8, 4);
        b6 = b5 - 32'd4000;
        sq = shr_s(b6 * b6, 12);
        x1 = shr_s(b2 * sq, 11);
        x2 = shr_s(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = shr_s(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
        x1 = shr_s(ac3 * b6, 13);
        x2 = shr_s(b1 * sq, 16);
        x3 = shr_s(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        b7 = ({13'd0, r.up} - b3) * (32'd50000 >> oss);
        if (b4 == 0) err = 1;
        p = 0;
        if (!err) begin
            if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
            else p = (b7 / b4) * 32'd2;
            x1 = shr_s(p, 8) * shr_s(p, 8);
            x1 = shr_s(x1 * 32'd3038, 16);
            x2 = shr_s(32'hFFFF_E343 * p, 16);
            p = p + shr_s(x1 + x2 + 32'd3791, 4);
        end
        if ($signed(t) > 32767) c.temp = 16'h7FFF;
        else if ($signed(t) < -32768) c.temp = 16'h8000;
        else c.temp = t[15:0];
        if (err || p[31]) c.pres = 0;
        else if (p > 32'd262143) c.pres = 18'h3FFFF;
        else c.pres = p[17:0];
        c.err = err;
        return c;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_q.size() > 0 && !send_hold &&
                $urandom_range(99) >= send_idle_pct) begin
                reading_t r;
                r = pending_q.pop_front();
                expected_q.push_back(compensate(r));
                s_raw_temperature <= r.ut;
                s_raw_pressure <= r.up;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                comp_t e;
                if (expected_q.size() == 0) begin
                    $display("%t unexpected result %h %h %b", $time,
                             m_temperature, m_pressure, m_divide_error);
                    failed = 1;
                end else begin
                    e = expected_q.pop_front();
                    if (e.temp !== m_temperature) begin
                        $display("%t temperature exp %h got %h", $time, e.temp,
                                 m_temperature);
                        failed = 1;
                    end
                    if (e.pres !== m_pressure) begin
                        $display("%t pressure exp %h got %h", $time, e.pres,
                                 m_pressure);
                        failed = 1;
                    end
                    if (e.err !== m_divide_error) begin
                        $display("%t divide_error exp %b got %b", $time, e.err,
                                 m_divide_error);
                        failed = 1;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_cal(input logic [2:0] idx, input logic [31:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx <= REG_OSS) cal_regs[idx] = (idx == REG_OSS) ? {30'd0, data[1:0]} : data;
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || expected_q.size() > 0 || s_valid)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic logic [31:0] rnd_half();
        case ($urandom_range(4))
            0: return 32'h0000;
            1: return 32'hFFFF;
            2: return 32'h8000;
            3: return 32'h7FFF;
            default: return $urandom_range(65535);
        endcase
    endfunction

    // typical datasheet calibration, mutated a little
    task automatic load_typical(input int jitter);
        logic [15:0] v[10];
        v = '{16'd408, -16'sd72, -16'sd14383, 16'd32741, 16'd32757, 16'd23153,
              16'd6190, 16'd4, -16'sd8711, 16'd2868};
        for (int i = 0; i < 10; i++)
            if (jitter != 0) v[i] = 16'(v[i] + $urandom_range(2 * jitter) - jitter);
        write_cal(REG_AC1_AC2, {v[0], v[1]});
        write_cal(REG_AC3_AC4, {v[2], v[3]});
        write_cal(REG_AC5_AC6, {v[4], v[5]});
        write_cal(REG_B1_B2, {v[6], v[7]});
        write_cal(REG_MC_MD, {v[8], v[9]});
    endtask

    task automatic load_random();
        logic [31:0] hi, lo;
        for (int i = 0; i < 5; i++) begin
            hi = rnd_half();
            lo = rnd_half();
            write_cal(i[2:0], {hi[15:0], lo[15:0]});
        end
    endtask

    task automatic queue_random(input int n, input bit realistic);
        reading_t r;
        repeat (n) begin
            if (realistic && $urandom_range(9) < 8) begin
                r.ut = 16'(16'd27898 + $urandom_range(6000) - 3000);
                r.up = 19'($urandom_range(200000, 20000));
            end else begin
                r.ut = 16'($urandom);
                r.up = 19'($urandom);
            end
            pending_q.push_back(r);
        end
    endtask

    initial begin
        reading_t r;
        failed = 0;
        send_hold = 0;
        send_idle_pct = 14;
        recv_idle_pct = 85;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_raw_temperature = '0;
        s_raw_pressure = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < 6; i++) cal_regs[i] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // all-zero calibration: both divisors zero
        r = '{16'd0, 19'd0}; pending_q.push_back(r);
        r = '{16'hFFFF, 19'h7FFFF}; pending_q.push_back(r);
        drain();
        load_typical(0);
        write_cal(REG_OSS, 32'd0);
        r = '{16'd27898, 19'd23843}; pending_q.push_back(r);
        r = '{16'd0, 19'd0}; pending_q.push_back(r);
        r = '{16'hFFFF, 19'h7FFFF}; pending_q.push_back(r);
        r = '{16'h8000, 19'h40000}; pending_q.push_back(r);
        drain();
        write_cal(REG_OSS, 32'hFFFF_FFFF);
        r = '{16'd27898, 19'd190000}; pending_q.push_back(r);
        r = '{16'hFFFF, 19'd0}; pending_q.push_back(r);
        drain();
        // zero temperature divisor: md cancels x1 (ut == ac6, x1 = 0, md = 0)
        write_cal(REG_MC_MD, {16'h8000, 16'h0000});
        r = '{16'd23153, 19'd1000}; pending_q.push_back(r);
        drain();
        // zero pressure divisor: ac4 = 0
        load_typical(0);
        write_cal(REG_AC3_AC4, {16'h8000, 16'h0000});
        r = '{16'd27898, 19'd23843}; pending_q.push_back(r);
        r = '{16'd1, 19'd7}; pending_q.push_back(r);
        drain();
        // index beyond the list is ignored
        write_cal(3'd7, 32'hDEAD_BEEF);
        write_cal(3'd6, 32'h1234_5678);
        r = '{16'd30000, 19'd5}; pending_q.push_back(r);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 14; recv_idle_pct = 85; end
                1: begin send_idle_pct = 85; recv_idle_pct = 14; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int k = 0; k < 8; k++) begin
                if (k % 3 == 2) load_random();
                else load_typical(k * 40);
                write_cal(REG_OSS, $urandom);
                queue_random(72, k % 3 != 2);
                if (k == 4) begin
                    while (pending_q.size() > 36) @(posedge aclk);
                    send_hold = 1;
                    while (expected_q.size() > 0) @(posedge aclk);
                    send_hold = 0;
                end
                drain();
            end
        end

        drain();
        if (!failed) $display("baro_temp_pressure_compensation: match");
        else $display("baro_temp_pressure_compensation: mismatch");
        $finish;
    end

    initial begin
        #30ms;
        $display("baro_temp_pressure_compensation: mismatch");
        $finish;
    end

endmodule
